@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker modules of the RTL folder.
// Depends on nothing; every macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is asserted.
`define FBPA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fbpa assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define FBPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`FBPA_ASSERT(label, clk, rst_n, (ante) |-> (cons))

// Consequent must hold in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	`FBPA_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

@@ hw/rtl/fbpa_pkg.sv @@
// Package of the fixed block pool allocator: codes, widths and reset values.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package fbpa_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 1024;

	// Port widths
	localparam int unsigned S_TDATA_W = 48; // req_size, req_alignment, block_index
	localparam int unsigned S_TUSER_W = 2;  // op
	localparam int unsigned M_TDATA_W = 24; // granted_index, free_blocks, zero fill
	localparam int unsigned M_TUSER_W = 3;  // status
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned GRANT_W = 10;
	localparam int unsigned FREE_W = 11;

	// Register reset values
	localparam logic [15:0] BLOCK_SIZE_RST = 16'd64;
	localparam logic [12:0] POOL_ALIGN_RST = 13'd8;
	localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;
	localparam logic [15:0] SIZE_FLOOR = 16'd8;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_REINIT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STATUS_OK          = 3'd0,
		STATUS_BAD_REQ     = 3'd1,
		STATUS_EMPTY       = 3'd2,
		STATUS_OUTSIDE     = 3'd3,
		STATUS_NOT_ALLOC   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_BLOCK_SIZE  = 2'd0,
		REG_POOL_ALIGN  = 2'd1,
		REG_BLOCK_COUNT = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ hw/rtl/fixed_block_pool_allocator_unit.sv @@
// Fixed block pool allocator: LIFO free list of block indexes kept in one pool memory.
// Depends on fbpa_pkg.
//
//   channel   direction  handshake                      contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  op, request size/alignment, index
//   m_axis    out        m_axis_tvalid / m_axis_tready  status, granted index, free count
//   cfg       in         cfg_valid / cfg_ready          register index and write data
//
// An item is read and then executed: on acceptance the pool memory is read (link and in-use
// flag of one entry) into a register, and in the execute state the entry is written back and
// the result loaded. Input is taken only while idle, and the execute state waits while the
// result register is full and not being taken.
// Reset and reinitialize need no clearing pass: blocks at or above a fill mark have not been
// handed out since and read as the ascending chain, not in use. Configuration never stalls.
`default_nettype none

module fixed_block_pool_allocator_unit #(
	parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [15:0] req_size, [31:16] req_alignment, [47:32] block_index
	input  wire logic [fbpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// [1:0] op
	input  wire logic [fbpa_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [9:0] granted_index, [20:10] free_blocks, [23:21] zero
	output logic [fbpa_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// [2:0] status
	output logic [fbpa_pkg::M_TUSER_W-1:0]        m_axis_tuser,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fbpa_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned WIDE_W = (CNT_W > 16) ? CNT_W : 16;
	localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] RESET_COUNT =
		(int'(BLOCK_COUNT_RST) > int'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(BLOCK_COUNT_RST);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [15:0] block_size_q;
	logic [12:0] pool_align_q;
	logic [10:0] block_count_q;

	// Free list bookkeeping
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] mark_q;  // entries below this have been written since the last relink
	logic [CNT_W-1:0] span_q;  // pool size at the last relink

	// Item held for the execute state
	op_t              op_s1;
	logic [15:0]      req_size_s1;
	logic [15:0]      req_align_s1;
	logic [15:0]      index_s1;
	logic [IDX_W:0]   rd_s1;  // {in_use, next_link}

	// Result register
	logic                out_valid_q;
	status_t             status_q;
	logic [GRANT_W-1:0]  granted_q;
	logic [FREE_W-1:0]   free_q;

	logic [IDX_W:0] pool_mem [MAX_BLOCKS];

	logic             in_acc;
	logic             exec_fire;
	logic [IDX_W-1:0] rd_addr;

	logic [15:0]       size_limit;
	logic [WIDE_W-1:0] count_wide;
	logic [WIDE_W-1:0] eff_wide;
	logic [CNT_W-1:0]  eff_count;
	logic              head_fresh;
	logic [CNT_W-1:0]  mark_inc;
	logic [IDX_W-1:0]  fresh_link;
	logic              index_in_range;
	logic              index_used;

	status_t          status_nx;
	logic [IDX_W-1:0] granted_nx;
	logic [IDX_W-1:0] head_nx;
	logic [CNT_W-1:0] total_nx;
	logic [CNT_W-1:0] mark_nx;
	logic [CNT_W-1:0] span_nx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W:0]   wr_data;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
	assign cfg_ready = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = status_q;
	assign m_axis_tdata = {3'b000, free_q, granted_q};

	// An allocate reads the entry at the head, a free the entry being returned.
	assign rd_addr = (op_t'(s_axis_tuser) == OP_FREE) ? s_axis_tdata[32 +: IDX_W] : head_q;

	always_comb begin
		size_limit = (block_size_q > SIZE_FLOOR) ? block_size_q : SIZE_FLOOR;
		count_wide = WIDE_W'(block_count_q);
		if (count_wide == '0) begin
			eff_wide = WIDE_W'(1);
		end else if (count_wide > MAX_WIDE) begin
			eff_wide = MAX_WIDE;
		end else begin
			eff_wide = count_wide;
		end
		eff_count = eff_wide[CNT_W-1:0];

		// The unwritten part of the list is the ascending run from the mark to the span.
		head_fresh = (CNT_W'(head_q) == mark_q);
		mark_inc = mark_q + CNT_W'(1);
		fresh_link = (mark_inc < span_q) ? mark_inc[IDX_W-1:0] : '0;

		index_in_range = WIDE_W'(index_s1) < eff_wide;
		index_used = (CNT_W'(index_s1) < mark_q) && rd_s1[IDX_W];

		status_nx = STATUS_OK;
		granted_nx = '0;
		head_nx = head_q;
		total_nx = total_q;
		mark_nx = mark_q;
		span_nx = span_q;
		wr_en = 1'b0;
		wr_addr = head_q;
		wr_data = {1'b1, {IDX_W{1'b0}}};

		case (op_s1)
			OP_ALLOC: begin
				if (req_size_s1 > size_limit || req_align_s1 > {3'b000, pool_align_q}) begin
					status_nx = STATUS_BAD_REQ;
				end else if (total_q == '0) begin
					status_nx = STATUS_EMPTY;
				end else begin
					granted_nx = head_q;
					total_nx = total_q - CNT_W'(1);
					wr_en = 1'b1;
					if (head_fresh) begin
						head_nx = fresh_link;
						mark_nx = mark_inc;
					end else begin
						head_nx = rd_s1[IDX_W-1:0];
					end
				end
			end
			OP_FREE: begin
				if (!index_in_range) begin
					status_nx = STATUS_OUTSIDE;
				end else if (!index_used) begin
					status_nx = STATUS_NOT_ALLOC;
				end else begin
					wr_en = 1'b1;
					wr_addr = index_s1[IDX_W-1:0];
					wr_data = {1'b0, head_q};
					head_nx = index_s1[IDX_W-1:0];
					total_nx = total_q + CNT_W'(1);
				end
			end
			OP_REINIT: begin
				head_nx = '0;
				total_nx = eff_count;
				mark_nx = '0;
				span_nx = eff_count;
			end
			default: begin
				status_nx = STATUS_BAD_REQ;
			end
		endcase
	end

	// Pool memory: one read port registered at acceptance, one write port.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= pool_mem[rd_addr];
		end
		if (exec_fire && wr_en) begin
			pool_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1 <= op_t'(s_axis_tuser);
			req_size_s1 <= s_axis_tdata[15:0];
			req_align_s1 <= s_axis_tdata[31:16];
			index_s1 <= s_axis_tdata[47:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			block_size_q <= BLOCK_SIZE_RST;
			pool_align_q <= POOL_ALIGN_RST;
			block_count_q <= BLOCK_COUNT_RST;
			head_q <= '0;
			total_q <= RESET_COUNT;
			mark_q <= '0;
			span_q <= RESET_COUNT;
			out_valid_q <= 1'b0;
			status_q <= STATUS_OK;
			granted_q <= '0;
			free_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_BLOCK_SIZE:  block_size_q <= cfg_data;
					REG_POOL_ALIGN:  pool_align_q <= cfg_data[12:0];
					REG_BLOCK_COUNT: block_count_q <= cfg_data[10:0];
					default: ;
				endcase
			end

			if (exec_fire) begin
				out_valid_q <= 1'b1;
				status_q <= status_nx;
				granted_q <= GRANT_W'(granted_nx);
				free_q <= FREE_W'(total_nx);
				head_q <= head_nx;
				total_q <= total_nx;
				mark_q <= mark_nx;
				span_q <= span_nx;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/fbpa_checker.sv @@
// Port-level checker of the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fbpa_checker #(
	parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	// [9:0] granted_index, [20:10] free_blocks, [23:21] zero
	input wire logic [fbpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [2:0] status
	input wire logic [fbpa_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import fbpa_pkg::*;

	// The block works on one item at a time, so it cannot take another straight away.
	`FBPA_ASSERT_NEXT(a_one_item_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	`FBPA_ASSERT_NEXT(a_result_held, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// Only a successful allocate names a block.
	`FBPA_ASSERT_IMPL(a_grant_zero_on_refusal, clk, arst_n, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata[9:0] == '0)

	`FBPA_ASSERT_IMPL(a_free_count_bounded, clk, arst_n, m_axis_tvalid, 32'(m_axis_tdata[20:10]) <= MAX_BLOCKS)

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker #(
	.MAX_BLOCKS(MAX_BLOCKS)
) u_fbpa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

`default_nettype wire

@@ test/fixed_block_pool_allocator_unit_tb.sv @@
// Self-checking testbench of fixed_block_pool_allocator_unit: directed and random
// allocate, free and reinitialise traffic against a free-list predictor held here.
// Depends on fbpa_pkg and the allocator top level only.
module fixed_block_pool_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam int POOL_DEPTH = MAX_BLOCKS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		status_t status;
		logic [GRANT_W-1:0] granted;
		logic [FREE_W-1:0] free_cnt;
	} pool_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies and free-list state of the predictor
	logic [15:0] cfg_block_size = BLOCK_SIZE_RST;
	logic [12:0] cfg_pool_align = POOL_ALIGN_RST;
	logic [10:0] cfg_block_count = BLOCK_COUNT_RST;
	logic [10:0] pool_link [POOL_DEPTH];
	bit pool_taken [POOL_DEPTH];
	logic [10:0] list_head;
	logic [10:0] list_free;

	pool_result_t pending_results[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	fixed_block_pool_allocator_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Zero and oversized counts are clamped into the pool.
	function automatic int pool_extent();
		int n;
		n = cfg_block_count;
		if (n < 1)
			n = 1;
		if (n > POOL_DEPTH)
			n = POOL_DEPTH;
		return n;
	endfunction

	function automatic void relink_pool_mirror();
		int n;
		n = pool_extent();
		for (int i = 0; i < POOL_DEPTH; i++) begin
			pool_link[i] = (i + 1 < n) ? 11'(i + 1) : 11'd0;
			pool_taken[i] = 1'b0;
		end
		list_head = '0;
		list_free = 11'(n);
	endfunction

	function automatic pool_result_t apply_request(logic [1:0] op, logic [15:0] size,
			logic [15:0] align, logic [15:0] idx);
		pool_result_t res;
		logic [15:0] limit;
		logic [9:0] slot;
		res.status = STATUS_OK;
		res.granted = '0;
		limit = (cfg_block_size > SIZE_FLOOR) ? cfg_block_size : SIZE_FLOOR;
		case (op)
			OP_ALLOC: begin
				if (size > limit || align > {3'b000, cfg_pool_align}) begin
					res.status = STATUS_BAD_REQ;
				end else if (list_free == 0) begin
					res.status = STATUS_EMPTY;
				end else begin
					slot = list_head[9:0];
					res.granted = slot;
					list_head = pool_link[slot];
					pool_taken[slot] = 1'b1;
					list_free = list_free - 11'd1;
				end
			end
			OP_FREE: begin
				if (int'(idx) >= pool_extent()) begin
					res.status = STATUS_OUTSIDE;
				end else if (!pool_taken[idx]) begin
					res.status = STATUS_NOT_ALLOC;
				end else begin
					pool_link[idx] = list_head;
					list_head = idx[10:0];
					pool_taken[idx] = 1'b0;
					list_free = list_free + 11'd1;
				end
			end
			OP_REINIT: begin
				relink_pool_mirror();
			end
			default: begin
				res.status = STATUS_BAD_REQ;
			end
		endcase
		res.free_cnt = list_free;
		return res;
	endfunction

	// Random allocated block, searched from a random start; -1 when none is out.
	function automatic int pick_allocated();
		int start;
		int k;
		start = $urandom_range(POOL_DEPTH - 1);
		for (int i = 0; i < POOL_DEPTH; i++) begin
			k = (start + i) % POOL_DEPTH;
			if (pool_taken[k])
				return k;
		end
		return -1;
	endfunction

	task automatic send_item(logic [1:0] op, logic [15:0] size, logic [15:0] align,
			logic [15:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {idx, align, size};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(apply_request(op, size, align, idx));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BLOCK_SIZE: cfg_block_size = value;
			REG_POOL_ALIGN: cfg_pool_align = value[12:0];
			REG_BLOCK_COUNT: cfg_block_count = value[10:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pool(logic [15:0] bsize, logic [15:0] align, logic [15:0] count);
		write_reg(REG_BLOCK_SIZE, bsize);
		write_reg(REG_POOL_ALIGN, align);
		write_reg(REG_BLOCK_COUNT, count);
	endtask

	// Mostly well-formed allocates and frees of blocks actually out, with some
	// reinitialises and a share of malformed or random items.
	task automatic pool_traffic(int n, int alloc_pct);
		int pick;
		int limit;
		int blk;
		logic [15:0] idx;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			limit = (cfg_block_size > SIZE_FLOOR) ? cfg_block_size : SIZE_FLOOR;
			if (pick < 2) begin
				send_item(OP_REINIT, 16'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick < 14) begin
				idx = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(pool_extent() + 1));
				send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom), idx);
			end else begin
				blk = ($urandom_range(99) < alloc_pct) ? -1 : pick_allocated();
				if (blk < 0)
					send_item(OP_ALLOC, 16'($urandom_range(limit)),
						16'($urandom_range(cfg_pool_align)), 16'($urandom));
				else
					send_item(OP_FREE, 16'($urandom), 16'($urandom), 16'(blk));
			end
		end
	endtask

	task automatic test_request_checks();
		// Reset state: ascending chain from block zero, 64 byte blocks, alignment 8.
		send_item(OP_ALLOC, 16'd0, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd64, 16'd8, 16'd0);
		send_item(OP_ALLOC, 16'd65, 16'd1, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'd9, 16'd0);
		send_item(OP_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_FREE, 16'd0, 16'd0, 16'hFFFF);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd1024);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd5);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd8, 16'd1, 16'd0);
		send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_REINIT, 16'd0, 16'd0, 16'd0);
	endtask

	task automatic test_two_block_pool();
		// The count shrinks without a reinitialise first, so the old list stays.
		set_pool(16'd0, 16'd0, 16'd2);
		send_item(OP_ALLOC, 16'd8, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd9, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd0, 16'd1, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd1);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd2);
		send_item(OP_REINIT, 16'd0, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'd0, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd1);
		send_item(OP_FREE, 16'd0, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'd0, 16'd0);
	endtask

	task automatic test_small_pools(int n);
		for (int r = 0; r < 4; r++) begin
			set_pool(16'($urandom_range(512, 1)), 16'($urandom_range(64, 1)),
				16'($urandom_range(16, 1)));
			send_item(OP_REINIT, 16'd0, 16'd0, 16'd0);
			pool_traffic(n / 4, 60);
		end
	endtask

	task automatic test_register_extremes(int n);
		logic [15:0] sizes [5] = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd9};
		logic [15:0] aligns [5] = '{16'd0, 16'd1, 16'd4096, 16'hFFFF, 16'h2005};
		logic [15:0] counts [5] = '{16'd0, 16'd1, 16'd2047, 16'd3, 16'd1024};
		for (int r = 0; r < 5; r++) begin
			set_pool(sizes[r], aligns[r], counts[r]);
			send_item(OP_REINIT, 16'd0, 16'd0, 16'd0);
			pool_traffic(n / 5, 60);
		end
	endtask

	task automatic test_count_without_reinit(int n);
		set_pool(16'd64, 16'd8, 16'd32);
		send_item(OP_REINIT, 16'd0, 16'd0, 16'd0);
		pool_traffic(n / 3, 80);
		write_reg(REG_BLOCK_COUNT, 16'd8);
		pool_traffic(n / 3, 50);
		write_reg(REG_BLOCK_COUNT, 16'd2047);
		pool_traffic(n / 3, 50);
	endtask

	task automatic test_full_pool(int n);
		set_pool(16'd4096, 16'd4096, 16'd1024);
		send_item(OP_REINIT, 16'd0, 16'd0, 16'd0);
		pool_traffic(n, 75);
	endtask

	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no request outstanding: status %0d", m_axis_tuser);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[9:0] !== want.granted) begin
					$error("granted_index: expected %0d, got %0d", want.granted,
						m_axis_tdata[9:0]);
					error_count++;
				end
				if (m_axis_tdata[20:10] !== want.free_cnt) begin
					$error("free_blocks: expected %0d, got %0d", want.free_cnt,
						m_axis_tdata[20:10]);
					error_count++;
				end
				if (m_axis_tdata[23:21] !== 3'b000) begin
					$error("tdata fill: expected 0, got %0d", m_axis_tdata[23:21]);
					error_count++;
				end
			end
		end
	end

	// Ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		relink_pool_mirror();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 60;
		test_request_checks();
		test_two_block_pool();
		test_small_pools(400);

		send_idle_pct = 60;
		recv_idle_pct = 16;
		test_register_extremes(350);
		test_count_without_reinit(210);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_full_pool(300);

		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
